FILE: rtl/core/lcdx_pkg.sv
// Shared types, codes and constants for the character LCD expander sequencer.
package lcdx_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DATA_SHIFT = 2'd0,
        CFG_RS_BIT     = 2'd1,
        CFG_ENABLE_BIT = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OP_INIT      = 3'd0,
        OP_COMMAND   = 3'd1,
        OP_CHAR      = 3'd2,
        OP_POSITION  = 3'd3,
        OP_CURSOR    = 3'd4,
        OP_BLINK     = 3'd5,
        OP_BACKLIGHT = 3'd6
    } t_op;

    // What the back end has to emit for one queued operation.
    typedef enum logic [1:0] {
        K_INIT = 2'd0,
        K_BYTE = 2'd1,
        K_BL   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;     // LCD byte, or display control for init
        logic       is_char;
        logic       bl;       // backlight as of this operation
    } t_entry;

    localparam logic [7:0] BACKLIGHT_MASK   = 8'h08;
    localparam logic [7:0] FUNCTION_SET_CMD = 8'h28;
    localparam logic [7:0] ENTRY_MODE_CMD   = 8'h06;
    localparam logic [7:0] HOME_CMD         = 8'h02;
    localparam logic [7:0] CURSOR_MASK      = 8'h02;
    localparam logic [7:0] BLINK_MASK       = 8'h01;
    localparam logic [7:0] DC_RESET         = 8'h0C;
    localparam logic [7:0] INIT_NIB_A       = 8'h30;
    localparam logic [7:0] INIT_NIB_B       = 8'h20;

    localparam logic [CFG_DATA_W-1:0] SHIFT_RESET  = 3'd4;
    localparam logic [CFG_DATA_W-1:0] RS_RESET     = 3'd0;
    localparam logic [CFG_DATA_W-1:0] ENABLE_RESET = 3'd2;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 5'd3;
    localparam logic [STEP_W-1:0] INIT_LAST_STEP = 5'd23;
    localparam logic [STEP_W-1:0] INIT_RAW_STEPS = 5'd8;

    function automatic logic [7:0] row_offset(input logic [1:0] row);
        logic [7:0] off;
        case (row)
            2'd0:    off = 8'h80;
            2'd1:    off = 8'hC0;
            2'd2:    off = 8'h14;
            default: off = 8'h54;
        endcase
        return off;
    endfunction

endpackage

FILE: rtl/core/lcdx_front.sv
// Front end: takes operations, tracks display control and backlight, queues work.
module lcdx_front
    import lcdx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [2:0] i_operation,
    input  logic [7:0] i_value,
    input  logic [5:0] i_column,
    input  logic [1:0] i_row,
    input  logic       i_enable_flag,
    output logic       o_stall,
    input  logic       i_full,
    output logic       o_push,
    output t_entry     o_entry
);

    logic [7:0] r_dc, n_dc;
    logic       r_bl, n_bl;
    logic       accept;
    logic       has_work;
    t_entry     entry;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;

    always_comb begin
        n_dc          = r_dc;
        n_bl          = r_bl;
        has_work      = 1'b1;
        entry.kind    = K_BYTE;
        entry.data    = i_value;
        entry.is_char = 1'b0;
        entry.bl      = r_bl;
        case (t_op'(i_operation))
            OP_INIT: begin
                entry.kind = K_INIT;
                entry.data = r_dc;
            end
            OP_COMMAND: ;
            OP_CHAR: begin
                entry.is_char = 1'b1;
            end
            OP_POSITION: begin
                entry.data = row_offset(i_row) + {2'b00, i_column};
            end
            OP_CURSOR: begin
                n_dc       = i_enable_flag ? (r_dc | CURSOR_MASK) : (r_dc & ~CURSOR_MASK);
                entry.data = n_dc;
            end
            OP_BLINK: begin
                n_dc       = i_enable_flag ? (r_dc | BLINK_MASK) : (r_dc & ~BLINK_MASK);
                entry.data = n_dc;
            end
            OP_BACKLIGHT: begin
                n_bl       = i_enable_flag;
                entry.kind = K_BL;
                entry.bl   = i_enable_flag;
            end
            default: begin
                // unused code: drop
                has_work = 1'b0;
            end
        endcase
    end

    assign o_push  = accept && has_work;
    assign o_entry = entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc <= DC_RESET;
            r_bl <= 1'b0;
        end else if (accept) begin
            r_dc <= n_dc;
            r_bl <= n_bl;
        end
    end

endmodule

FILE: rtl/core/lcdx_queue.sv
// Short queue of classified operations between front and back end.
module lcdx_queue
    import lcdx_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_entry,
    input  logic   i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/core/lcdx_back.sv
// Back end: expands the queue head into expander bytes, one per cycle unless the output stalls.
module lcdx_back
    import lcdx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_head_valid,
    input  t_entry                i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    output logic [7:0]            o_expander_byte,
    output logic                  o_last,
    input  logic                  i_stall
);

    logic [CFG_DATA_W-1:0] r_shift, r_rs, r_en;
    logic [STEP_W-1:0]     r_step;
    logic [STEP_W-1:0]     rel;
    logic                  r_out_valid;
    logic [7:0]            r_out;
    logic                  r_last;

    logic       load;
    logic [7:0] lcd_byte;
    logic [3:0] nib;
    logic [7:0] tag;
    logic [7:0] e_mask;
    logic [7:0] pre;
    logic [7:0] byte_out;
    logic       strobe;
    logic       is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= SHIFT_RESET;
            r_rs    <= RS_RESET;
            r_en    <= ENABLE_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_DATA_SHIFT: r_shift <= i_cfg_wdata;
                CFG_RS_BIT:     r_rs    <= i_cfg_wdata;
                CFG_ENABLE_BIT: r_en    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign rel    = r_step - INIT_RAW_STEPS;
    assign e_mask = 8'h01 << r_en;
    assign tag    = (i_head.is_char ? (8'h01 << r_rs) : 8'h00)
                  | (i_head.bl ? BACKLIGHT_MASK : 8'h00);
    assign nib    = r_step[1] ? lcd_byte[3:0] : lcd_byte[7:4];

    always_comb begin
        lcd_byte = i_head.data;
        pre      = (8'({4'b0000, nib}) << r_shift) | tag;
        strobe   = 1'b1;
        is_last  = 1'b0;
        case (i_head.kind)
            K_INIT: begin
                // command index runs over the four bytes after the raw nibbles
                case (rel[3:2])
                    2'd0:    lcd_byte = FUNCTION_SET_CMD;
                    2'd1:    lcd_byte = i_head.data;
                    2'd2:    lcd_byte = ENTRY_MODE_CMD;
                    default: lcd_byte = HOME_CMD;
                endcase
                if (r_step < INIT_RAW_STEPS) begin
                    pre = (r_step[2:1] == 2'd3) ? INIT_NIB_B : INIT_NIB_A;
                end
                is_last = (r_step == INIT_LAST_STEP);
            end
            K_BYTE: begin
                is_last = (r_step == BYTE_LAST_STEP);
            end
            K_BL: begin
                pre     = i_head.bl ? BACKLIGHT_MASK : 8'h00;
                strobe  = 1'b0;
                is_last = 1'b1;
            end
            default: begin
                is_last = 1'b1;
            end
        endcase
        // even steps raise E, odd steps drop it
        if (!strobe) begin
            byte_out = pre;
        end else if (r_step[0]) begin
            byte_out = pre & ~e_mask;
        end else begin
            byte_out = pre | e_mask;
        end
    end

    assign load  = i_head_valid && (!r_out_valid || !i_stall);
    assign o_pop = load && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_step      <= is_last ? '0 : r_step + 1'b1;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out  <= byte_out;
            r_last <= is_last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_expander_byte = r_out;
    assign o_last          = r_last;

endmodule

FILE: rtl/core/char_lcd_nibble_expander_sequencer.sv
// Top level: character LCD operations to I2C expander bytes for a 4-bit bus.
//
//  channel   direction  handshake           payload
//  op in     in         i_valid / o_stall   i_operation i_value i_column i_row i_enable_flag
//  bytes out out        o_valid / i_stall   o_expander_byte o_last
//  config    in         i_cfg_we            i_cfg_addr i_cfg_wdata
//
// The back end emits one expander byte per cycle; a stall on the output holds
// the byte. A command or character is 4 bytes, init 24, backlight 1. The queue
// of QUEUE_DEPTH operations lets the front keep accepting while the back end
// works; unused operation code 7 is taken and dropped. Reset is synchronous and
// restores the register defaults, display control 0x0C and backlight off.
module char_lcd_nibble_expander_sequencer
    import lcdx_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [2:0]            i_operation,
    input  logic [7:0]            i_value,
    input  logic [5:0]            i_column,
    input  logic [1:0]            i_row,
    input  logic                  i_enable_flag,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_expander_byte,
    output logic                  o_last
);

    logic   push, full, head_valid, pop;
    t_entry push_entry, head_entry;

    lcdx_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .i_column      (i_column),
        .i_row         (i_row),
        .i_enable_flag (i_enable_flag),
        .o_stall       (o_stall),
        .i_full        (full),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    lcdx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .o_valid (head_valid),
        .o_entry (head_entry),
        .i_pop   (pop)
    );

    lcdx_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_head_valid    (head_valid),
        .i_head          (head_entry),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .o_expander_byte (o_expander_byte),
        .o_last          (o_last),
        .i_stall         (i_stall)
    );

endmodule

FILE: rtl/core/lcdx_checker.sv
// Port-level checks for the LCD expander sequencer, bound to the top level.
module lcdx_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_expander_byte,
    input logic       o_last
);

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // reset empties the queue, so the input side is open
    a_reset_in: assert property (@(posedge i_clk) !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_expander_byte) && $stable(o_last))
        else $error("stalled output changed");

    // within one sequence the next byte follows the transfer without a gap
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_valid)
        else $error("gap inside a byte sequence");

endmodule

bind char_lcd_nibble_expander_sequencer lcdx_checker u_lcdx_checker (.*);

FILE: tb/tb.sv
// Self-checking testbench for the character LCD expander byte sequencer.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lcdx_pkg::*;

    localparam int LIMIT = 300000;
    localparam int SETTLE = 40;
    localparam int SEG_ITEMS = 66;
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] xbyte;
        logic       last;
    } t_lcd_out;

    class lcd_byte_scoreboard;
        t_lcd_out   byte_q[$];
        logic [7:0] row_base[4];
        logic [2:0] shift, rs_pos, en_pos;
        logic [7:0] disp_ctl;
        logic       bl_on;
        int         errors, checked;

        function new();
            row_base = '{8'h80, 8'hC0, 8'h14, 8'h54};
            shift = SHIFT_RESET;
            rs_pos = RS_RESET;
            en_pos = ENABLE_RESET;
            disp_ctl = DC_RESET;
            bl_on = 1'b0;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_DATA_SHIFT: shift = d;
                CFG_RS_BIT:     rs_pos = d;
                CFG_ENABLE_BIT: en_pos = d;
                default: ;
            endcase
        endfunction

        function void push_out(logic [7:0] b);
            t_lcd_out o;
            o.xbyte = b;
            o.last = 1'b0;
            byte_q.push_back(o);
        endfunction

        // E high, then the same byte with E forced low
        function void strobe(logic [7:0] b);
            logic [7:0] e;
            e = 8'h01 << en_pos;
            push_out(b | e);
            push_out(b & ~e);
        endfunction

        function void send_lcd(logic [7:0] b, logic is_char);
            logic [7:0] tag, hi, lo;
            tag = 8'h00;
            if (is_char) tag = tag | (8'h01 << rs_pos);
            if (bl_on) tag = tag | BACKLIGHT_MASK;
            hi = ({4'h0, b[7:4]} << shift) | tag;
            lo = ({4'h0, b[3:0]} << shift) | tag;
            strobe(hi);
            strobe(lo);
        endfunction

        function void expand_op(logic [2:0] op, logic [7:0] value, logic [5:0] column,
                                logic [1:0] row, logic flag);
            int         start;
            t_lcd_out   tail;
            logic [7:0] pos;
            start = byte_q.size();
            case (op)
                OP_INIT: begin
                    strobe(INIT_NIB_A);
                    strobe(INIT_NIB_A);
                    strobe(INIT_NIB_A);
                    strobe(INIT_NIB_B);
                    send_lcd(FUNCTION_SET_CMD, 1'b0);
                    send_lcd(disp_ctl, 1'b0);
                    send_lcd(ENTRY_MODE_CMD, 1'b0);
                    send_lcd(HOME_CMD, 1'b0);
                end
                OP_COMMAND: send_lcd(value, 1'b0);
                OP_CHAR:    send_lcd(value, 1'b1);
                OP_POSITION: begin
                    pos = row_base[row] + {2'b00, column};
                    send_lcd(pos, 1'b0);
                end
                OP_CURSOR: begin
                    disp_ctl = flag ? (disp_ctl | CURSOR_MASK) : (disp_ctl & ~CURSOR_MASK);
                    send_lcd(disp_ctl, 1'b0);
                end
                OP_BLINK: begin
                    disp_ctl = flag ? (disp_ctl | BLINK_MASK) : (disp_ctl & ~BLINK_MASK);
                    send_lcd(disp_ctl, 1'b0);
                end
                OP_BACKLIGHT: begin
                    bl_on = flag;
                    push_out(flag ? BACKLIGHT_MASK : 8'h00);
                end
                default: ;
            endcase
            if (byte_q.size() > start) begin
                tail = byte_q.pop_back();
                tail.last = 1'b1;
                byte_q.push_back(tail);
            end
        endfunction

        function void check_byte(logic [7:0] b, logic last);
            t_lcd_out want;
            if (byte_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected byte, expected none, actual %h last %b",
                         $time, b, last);
                return;
            end
            want = byte_q.pop_front();
            checked++;
            if (b !== want.xbyte) begin
                errors++;
                $display("%0t: expander_byte expected %h actual %h", $time, want.xbyte, b);
            end
            if (last !== want.last) begin
                errors++;
                $display("%0t: last expected %b actual %b", $time, want.last, last);
            end
        endfunction

        function int pending();
            return byte_q.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [2:0]            i_operation = '0;
    logic [7:0]            i_value = '0;
    logic [5:0]            i_column = '0;
    logic [1:0]            i_row = '0;
    logic                  i_enable_flag = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [7:0]            o_expander_byte;
    logic                  o_last;

    lcd_byte_scoreboard sb = new();
    int send_pct = 38;
    int stall_pct = 55;
    int cycles = 0;
    int ops_sent = 0;
    int dropped = 0;
    int settings = 0;

    char_lcd_nibble_expander_sequencer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_value         (i_value),
        .i_column        (i_column),
        .i_row           (i_row),
        .i_enable_flag   (i_enable_flag),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_expander_byte (o_expander_byte),
        .o_last          (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("%0t: timeout with %0d bytes outstanding", $time, sb.pending());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Byte receiver: check each transfer, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_byte(o_expander_byte, o_last);
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_item(logic [2:0] op, logic [7:0] v, logic [5:0] c, logic [1:0] r,
                             logic f);
        // idle cycle by cycle before offering the transfer
        while (send_pct != 0 && $urandom_range(99) < send_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_value <= v;
        i_column <= c;
        i_row <= r;
        i_enable_flag <= f;
        do @(posedge i_clk); while (o_stall);
        sb.expand_op(op, v, c, r, f);
        if (op == OP_UNUSED) dropped++;
        else ops_sent++;
    endtask

    // Hold off until every byte is out, then let the block settle
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, d);
        settings++;
        @(posedge i_clk);
    endtask

    task automatic configure(logic [2:0] sh, logic [2:0] rs, logic [2:0] en);
        set_reg(CFG_DATA_SHIFT, sh);
        set_reg(CFG_RS_BIT, rs);
        set_reg(CFG_ENABLE_BIT, en);
    endtask

    task automatic send_random(output logic ignored);
        logic [2:0] op;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 4) op = OP_INIT;
        else if (pick < 7) op = OP_UNUSED;
        else op = 3'($urandom_range(1, 6));
        send_item(op, 8'($urandom), 6'($urandom), 2'($urandom), 1'($urandom));
        ignored = (op == OP_UNUSED);
    endtask

    initial begin
        logic ignored;
        int   n;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, every operation, field extremes
        send_item(OP_INIT, 8'h00, 6'd0, 2'd0, 1'b0);
        send_item(OP_COMMAND, 8'h00, 6'd0, 2'd0, 1'b0);
        send_item(OP_COMMAND, 8'hFF, 6'd63, 2'd3, 1'b1);
        send_item(OP_CHAR, 8'hFF, 6'd0, 2'd0, 1'b0);
        send_item(OP_CHAR, 8'h00, 6'd63, 2'd3, 1'b1);
        send_item(OP_POSITION, 8'h00, 6'd0, 2'd0, 1'b0);
        send_item(OP_POSITION, 8'hFF, 6'd63, 2'd1, 1'b0);
        send_item(OP_POSITION, 8'h00, 6'd63, 2'd2, 1'b1);
        send_item(OP_POSITION, 8'h00, 6'd0, 2'd3, 1'b0);
        send_item(OP_CURSOR, 8'h00, 6'd0, 2'd0, 1'b1);
        send_item(OP_BLINK, 8'h00, 6'd0, 2'd0, 1'b1);
        send_item(OP_CURSOR, 8'hFF, 6'd0, 2'd0, 1'b0);
        send_item(OP_BLINK, 8'h00, 6'd0, 2'd0, 1'b0);
        send_item(OP_BACKLIGHT, 8'h00, 6'd0, 2'd0, 1'b1);
        send_item(OP_CHAR, 8'h5A, 6'd0, 2'd0, 1'b0);
        send_item(OP_UNUSED, 8'hFF, 6'd63, 2'd3, 1'b1);
        send_item(OP_BACKLIGHT, 8'h00, 6'd0, 2'd0, 1'b0);
        send_item(OP_INIT, 8'h00, 6'd0, 2'd0, 1'b1);

        // Large shift cuts data lines; everything at bit 7
        drain();
        configure(3'd7, 3'd7, 3'd7);
        send_item(OP_BACKLIGHT, 8'h00, 6'd0, 2'd0, 1'b1);
        send_item(OP_CHAR, 8'hA5, 6'd0, 2'd0, 1'b0);
        send_item(OP_INIT, 8'h00, 6'd0, 2'd0, 1'b0);

        // Unknown index must leave the rest alone; RS and E overlap the backlight bit
        drain();
        set_reg(CFG_UNUSED, 3'd5);
        configure(3'd0, 3'd3, 3'd3);
        send_item(OP_CHAR, 8'hFF, 6'd0, 2'd0, 1'b0);
        send_item(OP_BACKLIGHT, 8'h00, 6'd0, 2'd0, 1'b0);
        send_item(OP_CHAR, 8'h81, 6'd0, 2'd0, 1'b0);

        for (int seg = 0; seg < 6; seg++) begin
            drain();
            case (seg / 2)
                0: begin send_pct = 38; stall_pct = 55; end
                1: begin send_pct = 55; stall_pct = 38; end
                default: begin send_pct = 0; stall_pct = 0; end
            endcase
            case (seg)
                0: configure(SHIFT_RESET, RS_RESET, ENABLE_RESET);
                1: configure(3'd0, 3'd3, 3'd0);
                3: configure(3'd5, 3'd7, 3'd1);
                5: configure(SHIFT_RESET, RS_RESET, ENABLE_RESET);
                default: configure(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                                   3'($urandom_range(0, 7)));
            endcase
            n = 0;
            while (n < SEG_ITEMS) begin
                send_random(ignored);
                if (!ignored) n++;
            end
        end

        drain();
        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0t: %0d expected bytes never arrived", $time, sb.pending());
        end
        $display("Ran %0d operations and %0d dropped codes over %0d register writes,",
                 ops_sent, dropped, settings);
        $display("checking %0d expander bytes with mixed sender and receiver stalls.",
                 sb.checked);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: char_lcd_nibble_expander_sequencer.f
rtl/core/lcdx_pkg.sv
rtl/core/lcdx_front.sv
rtl/core/lcdx_queue.sv
rtl/core/lcdx_back.sv
rtl/core/char_lcd_nibble_expander_sequencer.sv
rtl/core/lcdx_checker.sv
tb/tb.sv
